// ----- sv/seven_segment_text_renderer_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the seven-segment text renderer
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TEXT_RENDERER_ASSERT_SVH
`define SEVEN_SEGMENT_TEXT_RENDERER_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle
`define SSTR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition in this cycle implies consequence in the next cycle
`define SSTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sstr_pkg.sv -----
// ---------------------------------------------------------------------------
// sstr_pkg
// Types, constants and glyph functions shared by the text renderer.
// ---------------------------------------------------------------------------
`default_nettype none

package sstr_pkg;

  // Abstract glyph: segments A..G in bits 0..6, decimal point in bit 7
  typedef logic [7:0] glyph_t;

  // Output bit position of each segment, index 7 is the decimal point
  typedef logic [7:0][3:0] pos_vec_t;

  localparam int NumPosRegs = 8;
  localparam pos_vec_t PosReset = {4'd2, 4'd6, 4'd8, 4'd1, 4'd10, 4'd0, 4'd9, 4'd5};

  localparam logic [7:0] DotCode = ".";
  localparam glyph_t     PointBit = 8'h80;
  localparam glyph_t     BlankGlyph = 8'h00;

  localparam glyph_t SegA = 8'h01;
  localparam glyph_t SegB = 8'h02;
  localparam glyph_t SegC = 8'h04;
  localparam glyph_t SegD = 8'h08;
  localparam glyph_t SegE = 8'h10;
  localparam glyph_t SegF = 8'h20;
  localparam glyph_t SegG = 8'h40;

  // Control to every cell of the chain
  typedef struct packed {
    logic load;   // copy display glyphs into the output chain, clear display
    logic shift;  // a character enters at the right end
    logic drain;  // output chain moves one cell toward the head
  } cell_ctrl_t;

  // Decode a character into abstract segments, blank when unknown
  function automatic glyph_t decode_glyph(input logic [7:0] code);
    glyph_t g;
    case (code)
      "0":                g = SegA | SegB | SegC | SegD | SegE | SegF;
      "1":                g = SegB | SegC;
      "2":                g = SegA | SegB | SegG | SegE | SegD;
      "3":                g = SegA | SegB | SegG | SegC | SegD;
      "4":                g = SegF | SegG | SegB | SegC;
      "5", "S", "s":      g = SegA | SegF | SegG | SegC | SegD;
      "6":                g = SegA | SegF | SegG | SegE | SegC | SegD;
      "7":                g = SegA | SegB | SegC;
      "8":                g = SegA | SegB | SegC | SegD | SegE | SegF | SegG;
      "9":                g = SegA | SegB | SegC | SegD | SegF | SegG;
      "-":                g = SegG;
      "_":                g = SegD;
      "A", "a":           g = SegA | SegB | SegC | SegE | SegF | SegG;
      "b":                g = SegC | SegD | SegE | SegF | SegG;
      "C", "c":           g = SegA | SegD | SegE | SegF;
      "d":                g = SegB | SegC | SegD | SegE | SegG;
      "E", "e":           g = SegA | SegD | SegE | SegF | SegG;
      "F", "f":           g = SegA | SegE | SegF | SegG;
      "H", "h":           g = SegB | SegC | SegE | SegF | SegG;
      "L", "l":           g = SegD | SegE | SegF;
      "P", "p":           g = SegA | SegB | SegE | SegF | SegG;
      "r":                g = SegE | SegG;
      "o":                g = SegC | SegD | SegE | SegG;
      "U", "u", "V", "v": g = SegB | SegC | SegD | SegE | SegF;
      default:            g = BlankGlyph;
    endcase
    return g;
  endfunction

  // Place each lit segment at its configured output bit; shared bits OR
  function automatic logic [15:0] map_glyph(input glyph_t g, input pos_vec_t pos);
    logic [15:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      if (g[k]) begin
        w = w | (16'd1 << pos[k]);
      end
    end
    return w;
  endfunction

  // Common line of each cell; cells past the fifth have line zero
  function automatic logic [2:0] line_of_cell(input logic [3:0] idx);
    logic [2:0] l;
    case (idx)
      4'd0:    l = 3'd7;
      4'd1:    l = 3'd6;
      4'd2:    l = 3'd5;
      4'd3:    l = 3'd3;
      4'd4:    l = 3'd2;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sstr_cell.sv -----
// ---------------------------------------------------------------------------
// sstr_cell
// One display cell: a display glyph fed from its right neighbor and an
// output glyph that drains toward the head of the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module sstr_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire sstr_pkg::cell_ctrl_t  ctrl,
  input  wire                        set_point,   // dot lands on this cell
  input  wire sstr_pkg::glyph_t      disp_in,     // display glyph from the right
  input  wire sstr_pkg::glyph_t      out_in,      // output glyph from the right
  output sstr_pkg::glyph_t           disp,
  output sstr_pkg::glyph_t           out_glyph
);

  sstr_pkg::glyph_t disp_hold;
  sstr_pkg::glyph_t disp_new;

  // Display value after this item's character or dot
  always_comb begin
    disp_hold = set_point ? (disp | sstr_pkg::PointBit) : disp;
    disp_new  = ctrl.shift ? disp_in : disp_hold;
  end

  // Display glyph: clear on flush, else shift or hold
  always_ff @(posedge clk) begin
    if (rst) begin
      disp <= sstr_pkg::BlankGlyph;
    end else if (ctrl.load) begin
      disp <= sstr_pkg::BlankGlyph;
    end else begin
      disp <= disp_new;
    end
  end

  // Output glyph: capture on flush, advance on drain
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_glyph <= disp_new;
    end else if (ctrl.drain) begin
      out_glyph <= out_in;
    end
  end

endmodule

`default_nettype wire

// ----- sv/seven_segment_text_renderer.sv -----
// ---------------------------------------------------------------------------
// seven_segment_text_renderer
// Text to seven-segment cell writes over a chain of display cells.
// ---------------------------------------------------------------------------
// Accepts one text word per cycle while s_axis_tready is high. A character
// shifts into the rightmost cell; a dot sets the decimal point of the latest
// character. An end-of-text word copies all NUM_CELLS cells into the output
// chain at once and clears the display; the output chain then gives NUM_CELLS
// words, left to right, one per cycle while m_axis_tready is high. Characters
// keep flowing during the drain; a further end-of-text word waits until the
// output chain hands out its last word (it is taken in that same cycle).
`default_nettype none

module seven_segment_text_renderer #(
  parameter int NUM_CELLS = 5
) (
  input  wire         clk,
  input  wire         rst,
  // configuration
  input  wire         cfg_we,
  input  wire  [3:0]  cfg_index,
  input  wire  [3:0]  cfg_data,
  // text input
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,    // [7:0] char_code
  input  wire         s_axis_tuser,    // [0] char_present
  input  wire         s_axis_tlast,    // end_of_text
  // cell writes
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,    // [2:0] common_line, [18:3] segment_word,
                                       // [34:19] clear_mask, [39:35] zero
  output logic        m_axis_tlast     // last_write
);

  sstr_pkg::pos_vec_t   positions;
  sstr_pkg::cell_ctrl_t ctrl;
  sstr_pkg::glyph_t     disp [NUM_CELLS];
  sstr_pkg::glyph_t     outg [NUM_CELLS];
  sstr_pkg::glyph_t     new_glyph;

  logic       char_seen;
  logic       out_valid;
  logic [3:0] line_idx;
  logic       s_take;
  logic       m_take;
  logic       last_idx;
  logic       is_dot;
  logic       set_point;

  // Segment position registers; writes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      positions <= sstr_pkg::PosReset;
    end else if (cfg_we && (int'(cfg_index) < sstr_pkg::NumPosRegs)) begin
      positions[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Input handshake and chain control
  always_comb begin
    last_idx      = (line_idx == 4'(NUM_CELLS - 1));
    m_take        = out_valid && m_axis_tready;
    s_axis_tready = !s_axis_tlast || !out_valid || (m_take && last_idx);
    s_take        = s_axis_tvalid && s_axis_tready;
    is_dot        = (s_axis_tdata == sstr_pkg::DotCode);
    set_point     = s_take && s_axis_tuser && is_dot && char_seen;
    new_glyph     = sstr_pkg::decode_glyph(s_axis_tdata);
    ctrl.shift    = s_take && s_axis_tuser && !is_dot;
    ctrl.load     = s_take && s_axis_tlast;
    ctrl.drain    = m_take;
  end

  // Track whether a character has entered since the last flush
  always_ff @(posedge clk) begin
    if (rst) begin
      char_seen <= 1'b0;
    end else if (ctrl.load) begin
      char_seen <= 1'b0;
    end else if (ctrl.shift) begin
      char_seen <= 1'b1;
    end
  end

  // Output chain state: which cell sits at the head
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      line_idx  <= 4'd0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
      line_idx  <= 4'd0;
    end else if (m_take) begin
      if (last_idx) begin
        out_valid <= 1'b0;
      end else begin
        line_idx <= line_idx + 4'd1;
      end
    end
  end

  // Row of cells, character enters at the right end
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    if (i == NUM_CELLS - 1) begin : g_right
      sstr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .set_point (set_point),
        .disp_in   (new_glyph),
        .out_in    (sstr_pkg::BlankGlyph),
        .disp      (disp[i]),
        .out_glyph (outg[i])
      );
    end else begin : g_inner
      sstr_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .set_point (1'b0),
        .disp_in   (disp[i+1]),
        .out_in    (outg[i+1]),
        .disp      (disp[i]),
        .out_glyph (outg[i])
      );
    end
  end

  // Map the head cell to output bits
  always_comb begin
    m_axis_tvalid       = out_valid;
    m_axis_tlast        = last_idx;
    m_axis_tdata        = '0;
    m_axis_tdata[2:0]   = sstr_pkg::line_of_cell(line_idx);
    m_axis_tdata[18:3]  = sstr_pkg::map_glyph(outg[0], positions);
    m_axis_tdata[34:19] = sstr_pkg::map_glyph(8'hFF, positions);
  end

  `include "seven_segment_text_renderer_assert.svh"

  `SSTR_ASSERT_NEXT(a_flush_starts, ctrl.load, out_valid && (line_idx == 4'd0), "flush did not start output at the first cell")
  `SSTR_ASSERT_NEXT(a_drain_ends, m_take && last_idx && !ctrl.load, !out_valid, "output chain still valid after its last word")
  `SSTR_ASSERT_NEXT(a_seen_clears, ctrl.load, !char_seen, "character mark survived a flush")

endmodule

`default_nettype wire

// ----- dv/seven_segment_text_renderer_tb.sv -----
// ---------------------------------------------------------------------------
// seven_segment_text_renderer_tb
// Self-checking testbench for the seven-segment text renderer. A directed
// table covers the corner cases of the text stream. Random runs of text
// follow under several segment position settings, with bursty input and a
// stalling receiver. Every cell write is checked against a local model of
// the glyph cells, or against the listed words of a typed directed row.
// ---------------------------------------------------------------------------
module seven_segment_text_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = 5;
  localparam int CycleLimit = 200000;
  localparam logic [15:0] MaskAtReset = 16'h0767;

  // Segment bits of the font
  localparam sstr_pkg::glyph_t SegA = sstr_pkg::SegA;
  localparam sstr_pkg::glyph_t SegB = sstr_pkg::SegB;
  localparam sstr_pkg::glyph_t SegC = sstr_pkg::SegC;
  localparam sstr_pkg::glyph_t SegD = sstr_pkg::SegD;
  localparam sstr_pkg::glyph_t SegE = sstr_pkg::SegE;
  localparam sstr_pkg::glyph_t SegF = sstr_pkg::SegF;
  localparam sstr_pkg::glyph_t SegG = sstr_pkg::SegG;

  // Register indexes of the configuration port; spare indexes are ignored
  typedef enum logic [3:0] {
    RegSegA, RegSegB, RegSegC, RegSegD, RegSegE, RegSegF, RegSegG, RegPoint,
    RegSpareLo, RegSpareHi = 4'd15
  } pos_reg_e;

  // Receiver stall patterns
  typedef enum logic [1:0] {RxOpen, RxCoin, RxThreeOfFour, RxOneOfEight} rx_mode_e;

  typedef struct packed {
    logic [2:0]  line;
    logic [15:0] word;
    logic [15:0] mask;
    logic        last;
  } cell_write_t;

  // One text word plus, where typed, the segment words it must flush
  typedef struct packed {
    logic [7:0]                  code;
    logic                        present;
    logic                        eot;
    logic                        typed;
    logic [CELLS-1:0][15:0]      typed_words;
  } text_row_t;

  localparam logic [CELLS-1:0][15:0] NoWords = '0;
  // Five eights at reset positions, the last one with its point
  localparam logic [CELLS-1:0][15:0] EightsPoint =
    {16'h0767, 16'h0763, 16'h0763, 16'h0763, 16'h0763};
  localparam logic [2:0] CellLine [CELLS] = '{3'd7, 3'd6, 3'd5, 3'd3, 3'd2};
  localparam string GlyphChars = "0123456789-_AaBbCcdEeFfHhLlPpoOrSsUuVv";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Local model state
  logic [3:0]       seg_pos [sstr_pkg::NumPosRegs];
  sstr_pkg::glyph_t cells [CELLS];
  logic             char_seen;
  cell_write_t      pending_writes [$];

  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int rx_tick = 0;
  rx_mode_e rx_mode = RxOpen;

  // Directed text: corner cases of dots, unknown codes and flushes
  text_row_t directed_rows [23] = '{
    '{8'h00,              1'b0, 1'b1, 1'b1, NoWords},     // flush right after reset: blank
    '{"8",                1'b1, 1'b0, 1'b0, NoWords},
    '{"8",                1'b1, 1'b0, 1'b0, NoWords},
    '{"8",                1'b1, 1'b0, 1'b0, NoWords},
    '{"8",                1'b1, 1'b0, 1'b0, NoWords},
    '{"8",                1'b1, 1'b0, 1'b0, NoWords},
    '{sstr_pkg::DotCode, 1'b1, 1'b1, 1'b1, EightsPoint}, // point on last eight, then flush
    '{sstr_pkg::DotCode, 1'b1, 1'b0, 1'b0, NoWords},     // leading dot: dropped
    '{8'hFF,              1'b1, 1'b0, 1'b0, NoWords},     // unknown code: blank cell
    '{"1",                1'b1, 1'b0, 1'b0, NoWords},
    '{sstr_pkg::DotCode, 1'b1, 1'b0, 1'b0, NoWords},
    '{sstr_pkg::DotCode, 1'b1, 1'b0, 1'b0, NoWords},     // repeated dot collapses
    '{8'hA5,              1'b0, 1'b0, 1'b0, NoWords},     // no char, no end: nothing
    '{"A",                1'b1, 1'b0, 1'b0, NoWords},
    '{"b",                1'b1, 1'b0, 1'b0, NoWords},
    '{"-",                1'b1, 1'b0, 1'b0, NoWords},
    '{"_",                1'b1, 1'b0, 1'b0, NoWords},
    '{"H",                1'b1, 1'b0, 1'b0, NoWords},     // seventh char pushes the second out
    '{sstr_pkg::DotCode, 1'b1, 1'b1, 1'b0, NoWords},     // dot and end in one word
    '{sstr_pkg::DotCode, 1'b1, 1'b1, 1'b1, NoWords},     // dot after flush: blank
    '{"7",                1'b1, 1'b1, 1'b0, NoWords},     // char and end in one word
    '{8'h00,              1'b1, 1'b0, 1'b0, NoWords},     // NUL code: blank cell
    '{8'h7F,              1'b0, 1'b1, 1'b1, NoWords}      // end only, code ignored
  };

  seven_segment_text_renderer #(.NUM_CELLS(CELLS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
    .s_axis_tuser  (s_axis_tuser),   // [0] char_present
    .s_axis_tlast  (s_axis_tlast),   // end_of_text
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [2:0] common_line, [18:3] segment_word,
                                     // [34:19] clear_mask, [39:35] zero
    .m_axis_tlast  (m_axis_tlast)    // last_write
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("seven_segment_text_renderer regression: fail");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Font of the display, segments A..G in bits 0..6
  function automatic sstr_pkg::glyph_t glyph_of_char(input logic [7:0] code);
    case (code)
      "0":                return SegA | SegB | SegC | SegD | SegE | SegF;
      "1":                return SegB | SegC;
      "2":                return SegA | SegB | SegD | SegE | SegG;
      "3":                return SegA | SegB | SegC | SegD | SegG;
      "4":                return SegB | SegC | SegF | SegG;
      "5", "S", "s":      return SegA | SegC | SegD | SegF | SegG;
      "6":                return SegA | SegC | SegD | SegE | SegF | SegG;
      "7":                return SegA | SegB | SegC;
      "8":                return SegA | SegB | SegC | SegD | SegE | SegF | SegG;
      "9":                return SegA | SegB | SegC | SegD | SegF | SegG;
      "-":                return SegG;
      "_":                return SegD;
      "A", "a":           return SegA | SegB | SegC | SegE | SegF | SegG;
      "b":                return SegC | SegD | SegE | SegF | SegG;
      "C", "c":           return SegA | SegD | SegE | SegF;
      "d":                return SegB | SegC | SegD | SegE | SegG;
      "E", "e":           return SegA | SegD | SegE | SegF | SegG;
      "F", "f":           return SegA | SegE | SegF | SegG;
      "H", "h":           return SegB | SegC | SegE | SegF | SegG;
      "L", "l":           return SegD | SegE | SegF;
      "P", "p":           return SegA | SegB | SegE | SegF | SegG;
      "r":                return SegE | SegG;
      "o":                return SegC | SegD | SegE | SegG;
      "U", "u", "V", "v": return SegB | SegC | SegD | SegE | SegF;
      default:            return sstr_pkg::BlankGlyph;
    endcase
  endfunction

  // Move each lit segment to its configured bit
  function automatic logic [15:0] place_segments(input sstr_pkg::glyph_t g);
    logic [15:0] w;
    w = '0;
    for (int k = 0; k < sstr_pkg::NumPosRegs; k++)
      if (g[k]) w |= 16'd1 << seg_pos[k];
    return w;
  endfunction

  // Advance the display model by one text word; queue its cell writes
  task automatic text_step(input logic [7:0] code, input logic present, input logic eot,
                           input bit record);
    logic [15:0] mask;
    if (present) begin
      if (code == sstr_pkg::DotCode) begin
        if (char_seen) cells[CELLS-1] |= sstr_pkg::PointBit;
      end else begin
        for (int i = 0; i < CELLS - 1; i++) cells[i] = cells[i+1];
        cells[CELLS-1] = glyph_of_char(code);
        char_seen = 1'b1;
      end
    end
    if (eot) begin
      mask = place_segments(8'hFF);
      for (int i = 0; i < CELLS; i++) begin
        if (record)
          pending_writes.push_back('{CellLine[i], place_segments(cells[i]), mask,
                                     i == CELLS - 1});
        cells[i] = sstr_pkg::BlankGlyph;
      end
      char_seen = 1'b0;
    end
  endtask

  // Drive one word in bursts with random gaps; predict it once taken
  task automatic send_word(input text_row_t row);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.code;
    s_axis_tuser  <= row.present;
    s_axis_tlast  <= row.eot;
    do @(posedge clk); while (!s_axis_tready);
    text_step(row.code, row.present, row.eot, !row.typed);
    if (row.typed)
      for (int i = 0; i < CELLS; i++)
        pending_writes.push_back('{CellLine[i], row.typed_words[i], MaskAtReset,
                                   i == CELLS - 1});
  endtask

  // Hold input until every expected write is out and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (CELLS + 3) @(posedge clk);
  endtask

  task automatic write_position(input logic [3:0] idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx < sstr_pkg::NumPosRegs) seg_pos[idx[2:0]] = val;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return GlyphChars[$urandom_range(0, GlyphChars.len() - 1)];
    if (r < 78) return sstr_pkg::DotCode;
    return 8'($urandom_range(0, 255));
  endfunction

  // One run of text: chars with dots and noise, usually closed by an end
  task automatic text_run(inout int sent);
    int len;
    bit merge;
    bit no_end;
    text_row_t row;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
    no_end = (len > 0) && ($urandom_range(0, 9) == 0);
    merge = !no_end && (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        row = '0;
        row.code = 8'($urandom_range(0, 255));
        send_word(row);
      end
      row = '0;
      row.code = pick_char();
      row.present = 1'b1;
      row.eot = merge && (i == len - 1);
      send_word(row);
      sent++;
    end
    if (!merge && !no_end) begin
      row = '0;
      row.code = 8'($urandom_range(0, 255));
      row.eot = 1'b1;
      send_word(row);
      sent++;
    end
  endtask

  task automatic play_random(input int budget, input bit with_pause);
    int sent;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < budget) begin
      if (with_pause && !paused && sent >= budget / 2) begin
        settle();
        paused = 1;
      end
      text_run(sent);
    end
    settle();
  endtask

  // Receiver: drive tready by a stall pattern picked at random on rx_tick
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 50 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RxOpen:        m_axis_tready <= 1'b1;
      RxCoin:        m_axis_tready <= 1'($urandom_range(0, 1));
      RxThreeOfFour: m_axis_tready <= (rx_tick % 4) != 0;
      default:       m_axis_tready <= (rx_tick % 8) == 0;
    endcase
  end

  // Check each cell write against the oldest expectation
  always @(posedge clk) begin : check_writes
    cell_write_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected cell write, tdata %h", m_axis_tdata));
      end else begin
        want = pending_writes.pop_front();
        if (m_axis_tdata[2:0] !== want.line)
          report($sformatf("common_line %0d, expected %0d", m_axis_tdata[2:0], want.line));
        if (m_axis_tdata[18:3] !== want.word)
          report($sformatf("segment_word %h, expected %h", m_axis_tdata[18:3], want.word));
        if (m_axis_tdata[34:19] !== want.mask)
          report($sformatf("clear_mask %h, expected %h", m_axis_tdata[34:19], want.mask));
        if (m_axis_tlast !== want.last)
          report($sformatf("last_write %b, expected %b", m_axis_tlast, want.last));
        if (m_axis_tdata[39:35] !== 5'd0)
          report($sformatf("tdata pad bits %b not zero", m_axis_tdata[39:35]));
      end
    end
  end

  initial begin
    for (int k = 0; k < sstr_pkg::NumPosRegs; k++) seg_pos[k] = sstr_pkg::PosReset[k];
    foreach (cells[i]) cells[i] = sstr_pkg::BlankGlyph;
    char_seen = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset positions: directed table, then random text with one full pause
    foreach (directed_rows[i]) send_word(directed_rows[i]);
    play_random(90, 1);

    // All segments on the top bit; spare index must not disturb anything
    for (int r = RegSegA; r <= RegPoint; r++) write_position(4'(r), 4'd15);
    write_position(RegSpareLo, 4'd0);
    cfg_we <= 1'b0;
    play_random(90, 0);

    // All segments on bit zero
    for (int r = RegSegA; r <= RegPoint; r++) write_position(4'(r), 4'd0);
    write_position(RegSpareHi, 4'd15);
    cfg_we <= 1'b0;
    play_random(90, 0);

    // Two random settings, shared bits likely
    repeat (2) begin
      for (int r = RegSegA; r <= RegPoint; r++)
        write_position(4'(r), 4'($urandom_range(0, 15)));
      write_position(4'($urandom_range(RegSpareLo, RegSpareHi)), 4'($urandom_range(0, 15)));
      cfg_we <= 1'b0;
      play_random(90, 0);
    end

    if (mismatches == 0) begin
      $display("seven_segment_text_renderer regression: pass");
    end else begin
      $display("seven_segment_text_renderer regression: fail");
    end
    $finish;
  end

endmodule
